@@ design/fcwl_pkg.sv @@
// Shared types and constants for the front-coded word list decoder.
// Used by every module of the block but fcwl_ram; depends on nothing else.
package fcwl_pkg;

    localparam int BUFFER_SIZE = 64;
    localparam int MAX_CHARS   = BUFFER_SIZE - 1;
    localparam int ADDR_W      = $clog2(MAX_CHARS);
    localparam int CNT_W       = 6;
    localparam int CHAR_W      = 7;
    localparam int BYTE_W      = 8;
    localparam int LETTER_W    = 5;
    localparam int ID_W        = 16;

    // Character code of the letter a.
    localparam logic [BYTE_W-1:0] LETTER_BASE = 8'h61;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_COUNT,
        PH_CHARS,
        PH_IDHI,
        PH_IDLO,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [CHAR_W-1:0] data;
    } store_wr_t;

    typedef struct packed {
        logic [CNT_W-1:0] len;
        logic [ID_W-1:0]  id;
    } word_cmd_t;

    typedef struct packed {
        logic [CHAR_W-1:0] word_char;
        logic [CNT_W-1:0]  char_position;
        logic [CNT_W-1:0]  word_length;
        logic [ID_W-1:0]   word_id;
        logic              last;
    } result_t;

endpackage

@@ design/front_coded_word_list_decoder.sv @@
// Front-coded word list decoder: the byte front end, command queue, prefix store
// and emitter. Depends on fcwl_pkg, fcwl_ram, fcwl_cmdq, fcwl_front, fcwl_back.
//
// Input side: a port that takes one stream byte per beat (push while full is
// low), with section_start marking the first byte of a letter section.
// Result side: a queue; while empty is low the oldest character beat is on
// word_char, char_position, word_length, word_id and last; pop takes it.
// When a word's low id byte arrives, the word goes to a two-entry command queue
// and the emitter reads it from the prefix store at one character per cycle
// while the output queue has room; the first beat passes the command queue,
// word registers, read stage and output queue. Character bytes of the next word
// and section clears wait until the emitter has read out every queued word,
// since they rewrite the prefix store; copy counts and id bytes keep flowing,
// the low id byte only while the command queue has room. Reset is asynchronous
// and active low; it empties both queues and returns to idle, with the store
// reading as all zeros. When the receiver stalls, two beats collect in the
// output queue, then the emitter, and later full, wait.
module front_coded_word_list_decoder (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [fcwl_pkg::BYTE_W-1:0]       data_byte,
    input  logic                              section_start,
    input  logic [fcwl_pkg::LETTER_W-1:0]     letter_index,
    output logic                              empty,
    input  logic                              pop,
    output logic [fcwl_pkg::CHAR_W-1:0]       word_char,
    output logic [fcwl_pkg::CNT_W-1:0]        char_position,
    output logic [fcwl_pkg::CNT_W-1:0]        word_length,
    output logic [fcwl_pkg::ID_W-1:0]         word_id,
    output logic                              last
);
    import fcwl_pkg::*;

    store_wr_t            wr;
    logic                 cmd_push;
    word_cmd_t            cmd_in;
    logic                 cmd_full;
    logic                 cmd_valid;
    logic                 cmd_pop;
    word_cmd_t            cmd_head;
    logic                 back_busy;
    logic [MAX_CHARS-1:0] store_vld;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic [CHAR_W-1:0]    rd_data;
    result_t              result;

    fcwl_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .data_byte     (data_byte),
        .section_start (section_start),
        .letter_index  (letter_index),
        .back_busy     (back_busy),
        .cmd_full      (cmd_full),
        .wr            (wr),
        .cmd_push      (cmd_push),
        .cmd           (cmd_in),
        .store_vld     (store_vld)
    );

    fcwl_cmdq u_cmdq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd_in),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .valid     (cmd_valid),
        .head      (cmd_head)
    );

    fcwl_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (MAX_CHARS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr.en),
        .wr_addr (wr.addr),
        .wr_data (wr.data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    fcwl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd_head),
        .cmd_pop   (cmd_pop),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .store_vld (store_vld),
        .busy      (back_busy),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    assign word_char     = result.word_char;
    assign char_position = result.char_position;
    assign word_length   = result.word_length;
    assign word_id       = result.word_id;
    assign last          = result.last;

endmodule

@@ design/fcwl_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the prefix characters of the decoder.
module fcwl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/fcwl_cmdq.sv @@
// Two-entry queue of finished words between the byte front end and the emitter.
// Depends on fcwl_pkg for the word command type.
module fcwl_cmdq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  fcwl_pkg::word_cmd_t push_data,
    output logic               full,
    input  logic               pop,
    output logic               valid,
    output fcwl_pkg::word_cmd_t head
);
    import fcwl_pkg::*;

    word_cmd_t  mem_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push_fire, pop_fire;

    assign full      = (cnt_reg == 2'd2);
    assign valid     = (cnt_reg != 2'd0);
    assign head      = mem_reg[rp_reg];
    assign push_fire = push && !full;
    assign pop_fire  = pop && valid;

    always_comb
    begin
        wp_next  = push_fire ? ~wp_reg : wp_reg;
        rp_next  = pop_fire ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push_fire} - {1'b0, pop_fire};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            mem_reg[wp_reg] <= push_data;
        end
    end

endmodule

@@ design/fcwl_front.sv @@
// Byte front end: parses copy counts, characters and ids, writes the prefix store
// and hands each finished word to the emitter. Depends on fcwl_pkg.
module fcwl_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [fcwl_pkg::BYTE_W-1:0]       data_byte,
    input  logic                              section_start,
    input  logic [fcwl_pkg::LETTER_W-1:0]     letter_index,
    input  logic                              back_busy,
    input  logic                              cmd_full,
    output fcwl_pkg::store_wr_t               wr,
    output logic                              cmd_push,
    output fcwl_pkg::word_cmd_t               cmd,
    output logic [fcwl_pkg::MAX_CHARS-1:0]    store_vld
);
    import fcwl_pkg::*;

    phase_t               phase_reg, phase_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [BYTE_W-1:0]    idhi_reg, idhi_next;
    logic [LETTER_W-1:0]  letter_reg, letter_next;
    logic                 first_reg, first_next;
    logic [CHAR_W-1:0]    prefix0_reg, prefix0_next;
    logic [MAX_CHARS-1:0] vld_reg, vld_next;
    logic                 clr_pend_reg, clr_pend_next;

    logic                 accept;
    logic                 clr_now;
    logic                 count_end;
    logic                 count_big;
    logic [CNT_W-1:0]     count_sat;
    phase_t               count_phase;
    logic [CNT_W-1:0]     cnt_inc;
    logic                 word_end;
    logic [CHAR_W-1:0]    char_dec;

    assign store_vld = vld_reg;
    assign cmd       = '{len: cnt_reg, id: {idhi_reg, data_byte}};

    // The store may only change once the emitter has read out every queued word.
    always_comb
    begin
        case (phase_reg)
            PH_IDLO:  full = cmd_full;
            PH_CHARS: full = back_busy || clr_pend_reg;
            default:  full = 1'b0;
        endcase
    end

    assign accept = push && !full;

    always_comb
    begin
        // A section start is always the first word, so only a zero count goes on.
        if (section_start || first_reg)
        begin
            count_end = (data_byte != '0);
        end
        else
        begin
            count_end = (data_byte == '0) &&
                        ({1'b0, prefix0_reg} == LETTER_BASE + {3'b000, letter_reg});
        end
        count_big   = (data_byte >= BYTE_W'(MAX_CHARS));
        count_sat   = count_big ? CNT_W'(MAX_CHARS) : data_byte[CNT_W-1:0];
        count_phase = count_end ? PH_DONE : (count_big ? PH_IDHI : PH_CHARS);
        cnt_inc     = cnt_reg + CNT_W'(1);
        word_end    = data_byte[BYTE_W-1] || (cnt_inc == CNT_W'(MAX_CHARS));
        char_dec    = ~data_byte[CHAR_W-1:0];
    end

    always_comb
    begin
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        idhi_next     = idhi_reg;
        letter_next   = letter_reg;
        first_next    = first_reg;
        prefix0_next  = prefix0_reg;
        vld_next      = vld_reg;
        clr_pend_next = clr_pend_reg;
        wr            = '0;
        cmd_push      = 1'b0;

        clr_now = clr_pend_reg && !back_busy;
        if (clr_now)
        begin
            vld_next      = '0;
            prefix0_next  = '0;
            clr_pend_next = 1'b0;
        end

        if (accept)
        begin
            if (section_start)
            begin
                letter_next   = letter_index;
                first_next    = 1'b1;
                clr_pend_next = 1'b1;
                phase_next    = count_phase;
                if (!count_end)
                begin
                    cnt_next = count_sat;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_COUNT:
                    begin
                        phase_next = count_phase;
                        if (!count_end)
                        begin
                            cnt_next = count_sat;
                        end
                    end
                    PH_CHARS:
                    begin
                        wr.en   = 1'b1;
                        wr.addr = cnt_reg[ADDR_W-1:0];
                        wr.data = char_dec;
                        vld_next[cnt_reg[ADDR_W-1:0]] = 1'b1;
                        if (cnt_reg == '0)
                        begin
                            prefix0_next = char_dec;
                        end
                        cnt_next = cnt_inc;
                        if (word_end)
                        begin
                            // The entry just past the word reads as zero from now on.
                            if (cnt_inc < CNT_W'(MAX_CHARS))
                            begin
                                vld_next[cnt_inc[ADDR_W-1:0]] = 1'b0;
                            end
                            phase_next = PH_IDHI;
                        end
                    end
                    PH_IDHI:
                    begin
                        idhi_next  = data_byte;
                        phase_next = PH_IDLO;
                    end
                    PH_IDLO:
                    begin
                        cmd_push   = 1'b1;
                        first_next = 1'b0;
                        phase_next = PH_COUNT;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            cnt_reg      <= '0;
            idhi_reg     <= '0;
            letter_reg   <= '0;
            first_reg    <= 1'b1;
            prefix0_reg  <= '0;
            vld_reg      <= '0;
            clr_pend_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            cnt_reg      <= cnt_next;
            idhi_reg     <= idhi_next;
            letter_reg   <= letter_next;
            first_reg    <= first_next;
            prefix0_reg  <= prefix0_next;
            vld_reg      <= vld_next;
            clr_pend_reg <= clr_pend_next;
        end
    end

    a_store_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> !back_busy && !clr_pend_reg)
        else $error("prefix store written while the emitter may still read it");

    a_cmd_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> !cmd_full)
        else $error("word handed over while the command queue is full");

    a_chars_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_CHARS |-> cnt_reg < CNT_W'(MAX_CHARS))
        else $error("character count out of range while reading characters");

endmodule

@@ design/fcwl_back.sv @@
// Emitter: reads each queued word from the prefix store one character per cycle
// while the result beats' two-entry output queue has room. Depends on fcwl_pkg.
module fcwl_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    input  fcwl_pkg::word_cmd_t            cmd,
    output logic                           cmd_pop,
    output logic                           rd_en,
    output logic [fcwl_pkg::ADDR_W-1:0]    rd_addr,
    input  logic [fcwl_pkg::CHAR_W-1:0]    rd_data,
    input  logic [fcwl_pkg::MAX_CHARS-1:0] store_vld,
    output logic                           busy,
    output logic                           empty,
    input  logic                           pop,
    output fcwl_pkg::result_t              result
);
    import fcwl_pkg::*;

    logic             active_reg, active_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [ID_W-1:0]  id_reg, id_next;

    logic             s1_vld_reg;
    logic [CNT_W-1:0] s1_pos_reg;
    logic             s1_last_reg;
    logic             s1_entv_reg;

    result_t          ob_mem_reg [2];
    logic             ob_wp_reg, ob_rp_reg;
    logic [1:0]       ob_cnt_reg, ob_cnt_next;

    logic             pop_fire;
    logic [1:0]       occ;
    logic             issue;
    logic             last_issue;
    logic             load;
    result_t          s1_result;

    assign empty    = (ob_cnt_reg == 2'd0);
    assign result   = ob_mem_reg[ob_rp_reg];
    assign pop_fire = pop && !empty;
    assign busy     = cmd_valid || active_reg;

    // Occupancy counts beats in flight from the store, so a read is only issued
    // when the output queue is sure to have room for its data.
    assign occ        = ob_cnt_reg + {1'b0, s1_vld_reg} - {1'b0, pop_fire};
    assign issue      = active_reg && (occ < 2'd2);
    assign last_issue = (pos_reg == len_reg - CNT_W'(1));
    assign load       = !active_reg && cmd_valid;
    assign cmd_pop    = load;
    assign rd_en      = issue;
    assign rd_addr    = pos_reg[ADDR_W-1:0];

    always_comb
    begin
        active_next = active_reg;
        pos_next    = pos_reg;
        len_next    = len_reg;
        id_next     = id_reg;
        if (load)
        begin
            active_next = (cmd.len != '0);
            pos_next    = '0;
            len_next    = cmd.len;
            id_next     = cmd.id;
        end
        else if (issue)
        begin
            pos_next = pos_reg + CNT_W'(1);
            if (last_issue)
            begin
                active_next = 1'b0;
            end
        end
        ob_cnt_next = ob_cnt_reg + {1'b0, s1_vld_reg} - {1'b0, pop_fire};
    end

    // Entries never written since the section start read as zero.
    always_comb
    begin
        s1_result.word_char     = s1_entv_reg ? rd_data : '0;
        s1_result.char_position = s1_pos_reg;
        s1_result.word_length   = len_reg;
        s1_result.word_id       = id_reg;
        s1_result.last          = s1_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
            ob_wp_reg  <= 1'b0;
            ob_rp_reg  <= 1'b0;
            ob_cnt_reg <= 2'd0;
        end
        else
        begin
            active_reg <= active_next;
            s1_vld_reg <= issue;
            ob_cnt_reg <= ob_cnt_next;
            if (s1_vld_reg)
            begin
                ob_wp_reg <= ~ob_wp_reg;
            end
            if (pop_fire)
            begin
                ob_rp_reg <= ~ob_rp_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        len_reg <= len_next;
        id_reg  <= id_next;
        if (issue)
        begin
            s1_pos_reg  <= pos_reg;
            s1_last_reg <= last_issue;
            s1_entv_reg <= store_vld[pos_reg[ADDR_W-1:0]];
        end
        if (s1_vld_reg)
        begin
            ob_mem_reg[ob_wp_reg] <= s1_result;
        end
    end

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, ob_cnt_reg} + {2'b00, s1_vld_reg}) <= 3'd2)
        else $error("output queue plus reads in flight exceed its two entries");

    a_data_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        s1_vld_reg |-> $past(rd_en))
        else $error("store data taken without a read the cycle before");

    a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.last) |->
            (result.char_position == result.word_length - CNT_W'(1)))
        else $error("last beat is not the final character of its word");

endmodule

@@ tb/fcwl_checker.sv @@
// Checker for the front-coded word list decoder: watches both queue sides,
// predicts the character beats of every decoded word and compares them.
// Depends on fcwl_pkg for widths, phase codes and the result layout.
module fcwl_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic                          full,
    input  logic [fcwl_pkg::BYTE_W-1:0]   data_byte,
    input  logic                          section_start,
    input  logic [fcwl_pkg::LETTER_W-1:0] letter_index,
    input  logic                          empty,
    input  logic                          pop,
    input  logic [fcwl_pkg::CHAR_W-1:0]   word_char,
    input  logic [fcwl_pkg::CNT_W-1:0]    char_position,
    input  logic [fcwl_pkg::CNT_W-1:0]    word_length,
    input  logic [fcwl_pkg::ID_W-1:0]     word_id,
    input  logic                          last,
    output int                            fail_count,
    output int                            outstanding
);
    import fcwl_pkg::*;

    logic [CHAR_W-1:0]   word_buf [0:MAX_CHARS-1];
    phase_t              state;
    logic [CNT_W-1:0]    fill;
    logic [BYTE_W-1:0]   id_msb;
    logic [LETTER_W-1:0] sect_letter;
    logic                opening_word;
    result_t             char_q [$];
    result_t             want;
    int                  mismatches;

    task automatic check_field(input string name, input logic [ID_W-1:0] exp_val,
                               input logic [ID_W-1:0] act_val);
        if (exp_val !== act_val)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_val, act_val);
            mismatches++;
        end
    endtask

    // A copy count either ends the section, kills a section whose first count
    // is not zero, or sets how many characters are kept from the last word.
    task automatic take_copy_count(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] k;
        k = b;
        if (opening_word && k != 0)
        begin
            state = PH_DONE;
        end
        else if (!opening_word && k == 0 &&
                 {1'b0, word_buf[0]} == LETTER_BASE + BYTE_W'(sect_letter))
        begin
            state = PH_DONE;
        end
        else
        begin
            if (k > MAX_CHARS)
            begin
                k = BYTE_W'(MAX_CHARS);
            end
            fill  = k[CNT_W-1:0];
            state = (k >= MAX_CHARS) ? PH_IDHI : PH_CHARS;
        end
    endtask

    task automatic predict_byte(input logic [BYTE_W-1:0] b, input logic s,
                                input logic [LETTER_W-1:0] l);
        result_t         r;
        logic [ID_W-1:0] id;
        int              p;
        if (s)
        begin
            for (p = 0; p < MAX_CHARS; p++)
            begin
                word_buf[p] = '0;
            end
            sect_letter  = l;
            opening_word = 1'b1;
            take_copy_count(b);
        end
        else
        begin
            case (state)
                PH_COUNT:
                begin
                    take_copy_count(b);
                end
                PH_CHARS:
                begin
                    if (fill < MAX_CHARS)
                    begin
                        word_buf[fill] = b[CHAR_W-1:0] ^ 7'h7F;
                        fill++;
                    end
                    if (b[7] || fill >= MAX_CHARS)
                    begin
                        // A zero marks the end of the word for later copies.
                        if (fill < MAX_CHARS)
                        begin
                            word_buf[fill] = '0;
                        end
                        state = PH_IDHI;
                    end
                end
                PH_IDHI:
                begin
                    id_msb = b;
                    state  = PH_IDLO;
                end
                PH_IDLO:
                begin
                    id = {id_msb, b};
                    for (p = 0; p < fill; p++)
                    begin
                        r.word_char     = word_buf[p];
                        r.char_position = CNT_W'(p);
                        r.word_length   = fill;
                        r.word_id       = id;
                        r.last          = (p + 1 == fill);
                        char_q.insert(char_q.size(), r);
                    end
                    opening_word = 1'b0;
                    state        = PH_COUNT;
                end
                default:
                begin
                end
            endcase
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CHARS; i++)
            begin
                word_buf[i] = '0;
            end
            state        = PH_IDLE;
            fill         = '0;
            id_msb       = '0;
            sect_letter  = '0;
            opening_word = 1'b1;
            char_q.delete();
            mismatches   = 0;
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (char_q.size() == 0)
                begin
                    $error("unexpected character beat: word_char %0h, word_id %0h",
                           word_char, word_id);
                    mismatches++;
                end
                else
                begin
                    want = char_q.pop_front();
                    check_field("word_char", ID_W'(want.word_char), ID_W'(word_char));
                    check_field("char_position", ID_W'(want.char_position),
                                ID_W'(char_position));
                    check_field("word_length", ID_W'(want.word_length),
                                ID_W'(word_length));
                    check_field("word_id", want.word_id, word_id);
                    check_field("last", ID_W'(want.last), ID_W'(last));
                end
            end
            if (push && !full)
            begin
                predict_byte(data_byte, section_start, letter_index);
            end
            fail_count  <= mismatches;
            outstanding <= char_q.size();
        end
    end

endmodule

@@ tb/tb_front_coded_word_list_decoder.sv @@
// Testbench top for the front-coded word list decoder: clock, reset, byte
// stimulus in bursts, a stalling receiver, a watchdog and the verdict.
// Depends on fcwl_pkg, fcwl_checker and the decoder itself.
module tb_front_coded_word_list_decoder;
    import fcwl_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int TAIL_CYCLES    = 20;
    localparam int TARGET_BYTES   = 200;

    typedef enum int {RX_STREAM, RX_RANDOM, RX_HOLD} rx_mode_t;

    logic                clk;
    logic                rst_n;
    logic                push;
    logic                full;
    logic [BYTE_W-1:0]   data_byte;
    logic                section_start;
    logic [LETTER_W-1:0] letter_index;
    logic                empty;
    logic                pop;
    logic [CHAR_W-1:0]   word_char;
    logic [CNT_W-1:0]    char_position;
    logic [CNT_W-1:0]    word_length;
    logic [ID_W-1:0]     word_id;
    logic                last;
    int                  fail_count;
    int                  outstanding;

    int       burst_left;
    int       bytes_sent;
    int       idle_cycles;
    int       rx_left;
    rx_mode_t rx_mode;

    front_coded_word_list_decoder DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .data_byte     (data_byte),
        .section_start (section_start),
        .letter_index  (letter_index),
        .empty         (empty),
        .pop           (pop),
        .word_char     (word_char),
        .char_position (char_position),
        .word_length   (word_length),
        .word_id       (word_id),
        .last          (last)
    );

    fcwl_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .data_byte     (data_byte),
        .section_start (section_start),
        .letter_index  (letter_index),
        .empty         (empty),
        .pop           (pop),
        .word_char     (word_char),
        .char_position (char_position),
        .word_length   (word_length),
        .word_id       (word_id),
        .last          (last),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // Receiver: streams, pops at random, or holds off for a while.
    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            rx_left = (rx_mode == RX_HOLD) ? $urandom_range(1, 24) : $urandom_range(5, 40);
        end
        rx_left--;
        case (rx_mode)
            RX_STREAM: pop <= 1'b1;
            RX_RANDOM: pop <= 1'($urandom_range(0, 1));
            default:   pop <= 1'b0;
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("front_coded_word_list_decoder test failed");
                $finish;
            end
        end
    end

    // Entered and left at a falling edge; push stays high within a burst.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic s,
                             input logic [LETTER_W-1:0] l);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 16);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        push          <= 1'b1;
        data_byte     <= b;
        section_start <= s;
        letter_index  <= l;
        do @(posedge clk); while (full);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_noise(input int n);
        repeat (n) send_byte(BYTE_W'($urandom()), 1'b0, LETTER_W'($urandom()));
    endtask

    task automatic send_section();
        logic [LETTER_W-1:0] letter;
        logic [CHAR_W-1:0]   letter_ch;
        logic [CHAR_W-1:0]   lead;
        logic [CHAR_W-1:0]   ch;
        logic [BYTE_W-1:0]   b;
        logic                lead_ends;
        int                  cnt;
        int                  nch;
        int                  prev_len;
        int                  words;
        int                  sel;
        bit                  cut;
        letter    = ($urandom_range(0, 9) == 0) ? LETTER_W'($urandom_range(26, 31))
                                                : LETTER_W'($urandom_range(0, 25));
        letter_ch = CHAR_W'(LETTER_BASE + BYTE_W'(letter));
        lead      = '0;
        prev_len  = 0;
        // A section whose first copy count is not zero produces nothing.
        if ($urandom_range(0, 9) == 0)
        begin
            send_byte(BYTE_W'($urandom_range(1, 255)), 1'b1, letter);
            send_noise($urandom_range(0, 3));
            return;
        end
        send_byte(8'h00, 1'b1, letter);
        words = $urandom_range(1, 6);
        for (int w = 0; w < words; w++)
        begin
            cnt = 0;
            if (w > 0)
            begin
                sel = $urandom_range(0, 19);
                if (sel == 0)
                begin
                    cnt = $urandom_range(MAX_CHARS, 255);
                end
                else if (sel > 3)
                begin
                    cnt = $urandom_range(1, (prev_len + 1 > 62) ? 62 : prev_len + 1);
                end
                send_byte(BYTE_W'(cnt), 1'b0, LETTER_W'($urandom()));
                lead_ends = ({1'b0, lead} == LETTER_BASE + BYTE_W'(letter));
                if (cnt == 0 && lead_ends)
                begin
                    send_noise($urandom_range(0, 3));
                    return;
                end
            end
            cut = ($urandom_range(0, 24) == 0);
            if (cnt < MAX_CHARS)
            begin
                if ($urandom_range(0, 11) == 0)
                begin
                    nch = MAX_CHARS - cnt;
                end
                else
                begin
                    nch = $urandom_range(1, (MAX_CHARS - cnt > 6) ? 6 : MAX_CHARS - cnt);
                end
                if (cut)
                begin
                    nch = $urandom_range(0, nch - 1);
                end
                for (int i = 0; i < nch; i++)
                begin
                    ch = CHAR_W'($urandom());
                    if (i == 0 && cnt == 0)
                    begin
                        // Words that open with the section letter let it end later.
                        if ((w == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 1) == 0))
                        begin
                            ch = letter_ch;
                        end
                        lead = ch;
                    end
                    b[CHAR_W-1:0] = ch ^ 7'h7F;
                    b[7]          = 1'b0;
                    if (i == nch - 1 && !cut)
                    begin
                        b[7] = (cnt + nch == MAX_CHARS) ? 1'($urandom_range(0, 1)) : 1'b1;
                    end
                    send_byte(b, 1'b0, LETTER_W'($urandom()));
                end
                prev_len = cnt + nch;
            end
            else
            begin
                prev_len = MAX_CHARS;
            end
            // A cut word is dropped by the next section start.
            if (cut)
            begin
                return;
            end
            case ($urandom_range(0, 5))
                0:       send_byte(8'h00, 1'b0, LETTER_W'($urandom()));
                1:       send_byte(8'hFF, 1'b0, LETTER_W'($urandom()));
                default: send_byte(BYTE_W'($urandom()), 1'b0, LETTER_W'($urandom()));
            endcase
            case ($urandom_range(0, 5))
                0:       send_byte(8'h00, 1'b0, LETTER_W'($urandom()));
                1:       send_byte(8'hFF, 1'b0, LETTER_W'($urandom()));
                default: send_byte(BYTE_W'($urandom()), 1'b0, LETTER_W'($urandom()));
            endcase
        end
        if ({1'b0, lead} == LETTER_BASE + BYTE_W'(letter))
        begin
            send_byte(8'h00, 1'b0, LETTER_W'($urandom()));
            send_noise($urandom_range(0, 3));
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        push          = 1'b0;
        data_byte     = '0;
        section_start = 1'b0;
        letter_index  = '0;
        pop           = 1'b0;
        burst_left    = 0;
        bytes_sent    = 0;
        idle_cycles   = 0;
        rx_left       = 0;
        rx_mode       = RX_STREAM;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Bytes before any section start are ignored.
        send_byte(8'hFF, 1'b0, 5'd31);
        send_byte(8'h00, 1'b0, 5'd0);
        // Section z: the word "z" with id zero.
        send_byte(8'h00, 1'b1, 5'd25);
        send_byte(8'h85, 1'b0, 5'd0);
        send_byte(8'h00, 1'b0, 5'd0);
        send_byte(8'h00, 1'b0, 5'd0);
        // Oversized copy count saturates: 63 characters, no character bytes.
        send_byte(8'hFF, 1'b0, 5'd0);
        send_byte(8'hFF, 1'b0, 5'd0);
        send_byte(8'hFF, 1'b0, 5'd0);
        // A zero count after a word starting with z ends the section.
        send_byte(8'h00, 1'b0, 5'd0);
        send_byte(8'h12, 1'b0, 5'd0);
        // Nonzero first copy count: nothing comes out of this section.
        send_byte(8'h05, 1'b1, 5'd3);
        send_byte(8'h00, 1'b0, 5'd3);
        send_byte(8'h80, 1'b0, 5'd3);
        // Letter index 31 lands past every 7-bit character, so it never matches.
        send_byte(8'h00, 1'b1, 5'd31);
        send_byte(8'h7F, 1'b0, 5'd0);
        send_byte(8'h00, 1'b0, 5'd0);
        send_byte(8'h80, 1'b0, 5'd0);
        send_byte(8'h12, 1'b0, 5'd0);
        send_byte(8'h34, 1'b0, 5'd0);
        // Zero count without a letter match starts a fresh word.
        send_byte(8'h00, 1'b0, 5'd0);
        send_byte(8'hC0, 1'b0, 5'd0);
        send_byte(8'hA5, 1'b0, 5'd0);
        send_byte(8'h5A, 1'b0, 5'd0);

        while (bytes_sent < TARGET_BYTES)
        begin
            send_section();
        end
        push <= 1'b0;

        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("front_coded_word_list_decoder test passed");
        end
        else
        begin
            $display("front_coded_word_list_decoder test failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/fcwl_pkg.sv
design/fcwl_ram.sv
design/fcwl_cmdq.sv
design/fcwl_front.sv
design/fcwl_back.sv
design/front_coded_word_list_decoder.sv
tb/fcwl_checker.sv
tb/tb_front_coded_word_list_decoder.sv
